[hw/rtl/huffman_tree_bit_decoder_assert.svh]
// Assertion macros for the Huffman tree bit decoder.
`ifndef HUFFMAN_TREE_BIT_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_BIT_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication check
`define HTBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check
`define HTBD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HTBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define HTBD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hw/rtl/htbd_pkg.sv]
// Shared types and constants of the Huffman tree bit decoder.
`timescale 1ns / 1ps
package htbd_pkg;

	localparam int DEF_NODES    = 512;
	localparam int MAX_CODE_LEN = 32;
	localparam int SYM_W        = 8;
	localparam int LEN_W        = 6;
	localparam int CODE_W       = 32;

	// opcodes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_BADLEN  = 2'd2;
	localparam logic [1:0] STAT_NOCHILD = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [SYM_W-1:0]  symbol;
		logic [LEN_W-1:0]  code_length;
		logic [CODE_W-1:0] code_bits;
		logic              stream_bit;
	} cmd_t;

	typedef struct packed {
		logic [SYM_W-1:0] out_symbol;
		logic             symbol_valid;
		logic [1:0]       status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LD_WALK,
		S_LD_RD,
		S_LD_MAKE,
		S_DEC_CHK,
		S_EMIT
	} state_t;

endpackage

[hw/rtl/htbd_in_if.sv]
// Input channel: one command transaction per valid/ready handshake.
`timescale 1ns / 1ps
interface htbd_in_if
	import htbd_pkg::*;
();
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/htbd_out_if.sv]
// Output channel: one result transaction per valid/ready handshake.
`timescale 1ns / 1ps
interface htbd_out_if
	import htbd_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/htbd_node_ram.sv]
// Node table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module htbd_node_ram
	import htbd_pkg::*;
#(
	parameter int DEPTH = DEF_NODES,
	parameter int WIDTH = 2 * $clog2(DEF_NODES) + SYM_W + 1,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/huffman_tree_bit_decoder.sv]
// Huffman decoder that walks a code tree held in a node table memory.
// Every command transaction gives exactly one result transaction. A decode bit picks, in the
// accept cycle, the child from the cached children of the current node and issues the node
// memory read; the next cycle checks whether that child has children. A clear, a bad code
// length, a missing child or an unknown opcode finish in the accept cycle. A load walks the
// nodes of its code that already exist, each with one node memory read and a check, then makes
// each new node with one write. An item whose result finds the output register still occupied
// waits in the emit state until the output register is free. The root's children live in
// flops, so the memory needs no clearing pass after reset or clear; stale entries are only
// reached through links written after the clear.
`timescale 1ns / 1ps
`include "huffman_tree_bit_decoder_assert.svh"
module huffman_tree_bit_decoder
	import htbd_pkg::*;
#(
	parameter int NODES = DEF_NODES
) (
	input  logic          clk,
	input  logic          arst_n,
	htbd_in_if.sink       cmd,
	htbd_out_if.source    res
);

	localparam int IDX_W = $clog2(NODES);
	localparam int NU_W  = $clog2(NODES + 1);
	localparam int ENT_W = 2 * IDX_W + SYM_W + 1;
	localparam int FW    = ((NU_W > LEN_W) ? NU_W : LEN_W) + 1;

	// entry layout: {leaf, symbol, right child, left child}
	localparam int K1_LO  = IDX_W;
	localparam int SYM_LO = 2 * IDX_W;

	state_t state_q, state_d;

	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] ck0_q, ck1_q;
	logic [IDX_W-1:0] rk0_q, rk1_q;
	logic [NU_W-1:0]  nu_q;
	logic [IDX_W-1:0] n_q;
	logic [ENT_W-1:0] nent_q;
	logic [LEN_W-1:0] d_q;
	logic [LEN_W-1:0] len_q;
	logic [SYM_W-1:0] sym_q;
	logic [CODE_W-1:0] code_q;
	logic [IDX_W-1:0] dc_q;
	rsp_t             res_q, pend_q;
	logic             res_valid_q;

	logic             accept;
	logic             out_free;
	logic [IDX_W-1:0] cur_k0, cur_k1, dec_c;
	logic             bad_len;
	logic [LEN_W-1:0] pos;
	logic             path_b;
	logic [IDX_W-1:0] walk_c;
	logic             walk_go;
	logic             full;
	logic             make_more;
	logic [IDX_W-1:0] new_c;
	logic             dchk_leaf;
	logic             fin;
	state_t           fin_next;
	rsp_t             fin_res;

	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [ENT_W-1:0] rd_data, wr_data;

	htbd_node_ram #(
		.DEPTH (NODES),
		.WIDTH (ENT_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// handshake
	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !res_valid_q || res.ready;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// children of the current decode node; root children sit in flops
	assign cur_k0 = (cur_q == '0) ? rk0_q : ck0_q;
	assign cur_k1 = (cur_q == '0) ? rk1_q : ck1_q;
	assign dec_c  = cmd.data.stream_bit ? cur_k1 : cur_k0;

	assign bad_len = (cmd.data.code_length == '0) ||
		({1'b0, cmd.data.code_length} > (LEN_W + 1)'(MAX_CODE_LEN));

	// code bit at depth d, bits above the code word read as zero
	assign pos    = len_q - LEN_W'(1) - d_q;
	assign path_b = (pos < LEN_W'(CODE_W)) ? code_q[pos[4:0]] : 1'b0;
	assign walk_c = path_b ? nent_q[K1_LO +: IDX_W] : nent_q[IDX_W-1:0];
	assign walk_go = (d_q < len_q) && (walk_c != '0);
	assign full    = (FW'(nu_q) + FW'(len_q - d_q)) > FW'(NODES);
	assign make_more = (d_q < len_q);
	assign new_c     = nu_q[IDX_W-1:0];
	assign dchk_leaf = (rd_data[IDX_W-1:0] == '0) && (rd_data[K1_LO +: IDX_W] == '0);
	assign fin_next  = out_free ? S_IDLE : S_EMIT;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.data.opcode)
						OP_LOAD:   state_d = bad_len ? fin_next : S_LD_WALK;
						OP_DECODE: state_d = (dec_c == '0) ? fin_next : S_DEC_CHK;
						default:   state_d = fin_next;
					endcase
				end
			end
			S_LD_WALK: begin
				if (walk_go) begin
					state_d = S_LD_RD;
				end else if (full) begin
					state_d = fin_next;
				end else begin
					state_d = S_LD_MAKE;
				end
			end
			S_LD_RD:   state_d = S_LD_WALK;
			S_LD_MAKE: state_d = make_more ? S_LD_MAKE : fin_next;
			S_DEC_CHK: state_d = fin_next;
			S_EMIT:    state_d = out_free ? S_IDLE : S_EMIT;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls and result of a finishing item
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = dec_c;
		wr_en   = 1'b0;
		wr_addr = n_q;
		wr_data = {1'b1, sym_q, nent_q[SYM_LO-1:0]};
		fin     = 1'b0;
		fin_res = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.data.opcode)
						OP_LOAD: begin
							fin            = bad_len;
							fin_res.status = STAT_BADLEN;
						end
						OP_DECODE: begin
							if (dec_c == '0) begin
								fin            = 1'b1;
								fin_res.status = STAT_NOCHILD;
							end else begin
								rd_en = 1'b1;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_LD_WALK: begin
				rd_addr = walk_c;
				if (walk_go) begin
					rd_en = 1'b1;
				end else if (full) begin
					fin            = 1'b1;
					fin_res.status = STAT_FULL;
				end
			end
			S_LD_MAKE: begin
				if (make_more) begin
					// link the new node; the root links are kept in flops
					wr_en   = (n_q != '0);
					wr_data = path_b ?
						{nent_q[ENT_W-1:SYM_LO], new_c, nent_q[IDX_W-1:0]} :
						{nent_q[ENT_W-1:K1_LO], new_c};
				end else begin
					wr_en = 1'b1;
					fin   = 1'b1;
				end
			end
			S_DEC_CHK: begin
				fin = 1'b1;
				if (dchk_leaf) begin
					fin_res.out_symbol   = rd_data[SYM_LO +: SYM_W];
					fin_res.symbol_valid = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			rk0_q       <= '0;
			rk1_q       <= '0;
			nu_q        <= NU_W'(1);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin && out_free) begin
				res_valid_q <= 1'b1;
			end else if (state_q == S_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && cmd.data.opcode == OP_CLEAR) begin
						rk0_q <= '0;
						rk1_q <= '0;
						nu_q  <= NU_W'(1);
						cur_q <= '0;
					end else if (accept && cmd.data.opcode == OP_DECODE && dec_c == '0) begin
						cur_q <= '0;
					end
				end
				S_LD_MAKE: begin
					if (make_more) begin
						nu_q <= nu_q + NU_W'(1);
						if (n_q == '0) begin
							if (path_b) begin
								rk1_q <= new_c;
							end else begin
								rk0_q <= new_c;
							end
						end
					end
				end
				S_DEC_CHK: begin
					cur_q <= dchk_leaf ? '0 : dc_q;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fin && out_free) begin
			res_q <= fin_res;
		end else if (fin) begin
			pend_q <= fin_res;
		end else if (state_q == S_EMIT && out_free) begin
			res_q <= pend_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					len_q  <= cmd.data.code_length;
					sym_q  <= cmd.data.symbol;
					code_q <= cmd.data.code_bits;
					dc_q   <= dec_c;
					n_q    <= '0;
					d_q    <= '0;
					nent_q <= {1'b0, {SYM_W{1'b0}}, rk1_q, rk0_q};
				end
			end
			S_LD_WALK: begin
				if (walk_go) begin
					n_q <= walk_c;
					d_q <= d_q + LEN_W'(1);
				end
			end
			S_LD_RD: nent_q <= rd_data;
			S_LD_MAKE: begin
				if (make_more) begin
					// keep the decode cache coherent with the linked node
					if (n_q != '0 && n_q == cur_q) begin
						if (path_b) begin
							ck1_q <= new_c;
						end else begin
							ck0_q <= new_c;
						end
					end
					n_q    <= new_c;
					nent_q <= '0;
					d_q    <= d_q + LEN_W'(1);
				end
			end
			S_DEC_CHK: begin
				ck0_q <= rd_data[IDX_W-1:0];
				ck1_q <= rd_data[K1_LO +: IDX_W];
			end
			default: ;
		endcase
	end

	// checks
	`HTBD_ASSERT_IMP(a_nu_range, clk, arst_n, 1'b1, (nu_q != '0) && (nu_q <= NODES), "node count out of range")
	`HTBD_ASSERT_IMP(a_no_root_wr, clk, arst_n, wr_en, wr_addr != '0, "memory write to root entry")
	`HTBD_ASSERT_IMP(a_room, clk, arst_n, (state_q == S_LD_MAKE) && make_more, nu_q < NODES, "node created past table end")
	`HTBD_ASSERT_NXT(a_leaf_root, clk, arst_n, (state_q == S_DEC_CHK) && dchk_leaf, cur_q == '0, "decode did not return to root")

endmodule

[bench/tb_huffman_tree_bit_decoder.sv]
// Self-checking bench for the Huffman tree bit decoder: directed tree edits plus random code sets.
`timescale 1ns / 1ps
module tb_huffman_tree_bit_decoder;
	import htbd_pkg::*;

	localparam int         TB_NODES  = DEF_NODES;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         IDLE_PCT  = 34;
	localparam int         MAX_SHOWN = 10;

	logic clk;
	logic arst_n;
	bit   burst_mode;

	htbd_in_if  cmd_ch ();
	htbd_out_if res_ch ();

	huffman_tree_bit_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// Shadow copy of the code tree; the leaf mark never reaches a result, so it is not kept
	logic [9:0]  kid_tab [TB_NODES][2];
	logic [7:0]  sym_tab [TB_NODES];
	int unsigned nodes_used;
	int unsigned cur_node;

	rsp_t results_due [$];

	int items_sent, n_clear, n_load, n_bits, n_other;
	int n_checked, n_decoded, n_full, n_badlen, n_nochild;
	int err_cnt;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side back-pressure
	always @(negedge clk) begin
		res_ch.ready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
	end

	// Compare every result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			n_checked++;
			if (results_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("%0t: result with nothing pending: sym %02h valid %0b status %0d",
						$realtime, res_ch.data.out_symbol, res_ch.data.symbol_valid,
						res_ch.data.status);
			end else begin
				want = results_due.pop_front();
				if (res_ch.data.out_symbol !== want.out_symbol ||
						res_ch.data.symbol_valid !== want.symbol_valid ||
						res_ch.data.status !== want.status) begin
					err_cnt++;
					if (err_cnt <= MAX_SHOWN)
						$display({"%0t: mismatch: want sym %02h valid %0b status %0d, ",
							"got sym %02h valid %0b status %0d"},
							$realtime, want.out_symbol, want.symbol_valid, want.status,
							res_ch.data.out_symbol, res_ch.data.symbol_valid,
							res_ch.data.status);
				end
			end
		end
	end

	// Empty tree: root only, walk back at the root
	function automatic void tree_clear();
		for (int i = 0; i < TB_NODES; i++) begin
			kid_tab[i][0] = '0;
			kid_tab[i][1] = '0;
			sym_tab[i]    = '0;
		end
		nodes_used = 1;
		cur_node   = 0;
	endfunction

	// Depth that the existing tree covers along a code; node is where it stops
	function automatic int unsigned tree_reach(input int unsigned len, input logic [31:0] bits,
			output int unsigned node);
		int unsigned d;
		d    = 0;
		node = 0;
		while (d < len && kid_tab[node][bits[len - 1 - d]] != 0) begin
			node = kid_tab[node][bits[len - 1 - d]];
			d++;
		end
		return d;
	endfunction

	// Expected result of one command; updates the shadow tree
	function automatic rsp_t walk_tree(input cmd_t c);
		rsp_t        r;
		int unsigned len, d, n, nn;
		logic [9:0]  kid;
		r = '0;
		case (c.opcode)
			OP_CLEAR: tree_clear();
			OP_LOAD: begin
				len = c.code_length;
				if (len == 0 || len > MAX_CODE_LEN) begin
					r.status = STAT_BADLEN;
				end else begin
					d = tree_reach(len, c.code_bits, n);
					// all missing nodes must fit, else nothing is built
					if (nodes_used + (len - d) > TB_NODES) begin
						r.status = STAT_FULL;
					end else begin
						for (int unsigned i = d; i < len; i++) begin
							nn = nodes_used;
							nodes_used++;
							kid_tab[nn][0] = '0;
							kid_tab[nn][1] = '0;
							sym_tab[nn]    = '0;
							kid_tab[n][c.code_bits[len - 1 - i]] = 10'(nn);
							n = nn;
						end
						sym_tab[n] = c.symbol;
					end
				end
			end
			OP_DECODE: begin
				kid = kid_tab[cur_node][c.stream_bit];
				if (kid == 0 || kid >= TB_NODES) begin
					r.status = STAT_NOCHILD;
					cur_node = 0;
				end else if (kid_tab[kid][0] == 0 && kid_tab[kid][1] == 0) begin
					r.out_symbol   = sym_tab[kid];
					r.symbol_valid = 1'b1;
					cur_node       = 0;
				end else begin
					cur_node = kid;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Command with every field random except the opcode
	function automatic cmd_t rand_cmd(input logic [1:0] op);
		cmd_t c;
		c.opcode      = op;
		c.symbol      = 8'($urandom());
		c.code_length = 6'($urandom());
		c.code_bits   = $urandom();
		c.stream_bit  = 1'($urandom());
		return c;
	endfunction

	// Drive one command transaction and record its prediction on acceptance
	task automatic send_cmd(input cmd_t c);
		rsp_t r;
		@(negedge clk);
		while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do begin
			@(posedge clk);
		end while (cmd_ch.ready !== 1'b1);
		r = walk_tree(c);
		results_due.push_back(r);
		items_sent++;
		case (c.opcode)
			OP_CLEAR:  n_clear++;
			OP_LOAD:   n_load++;
			OP_DECODE: n_bits++;
			default:   n_other++;
		endcase
		case (r.status)
			STAT_FULL:    n_full++;
			STAT_BADLEN:  n_badlen++;
			STAT_NOCHILD: n_nochild++;
			default: ;
		endcase
		if (r.symbol_valid)
			n_decoded++;
	endtask

	task automatic send_op(input logic [1:0] op);
		send_cmd(rand_cmd(op));
	endtask

	task automatic send_bit(input logic b);
		cmd_t c;
		c = rand_cmd(OP_DECODE);
		c.stream_bit = b;
		send_cmd(c);
	endtask

	task automatic send_load(input logic [7:0] sym, input int unsigned len,
			input logic [31:0] bits);
		cmd_t        c;
		logic [31:0] keep;
		c = rand_cmd(OP_LOAD);
		c.symbol      = sym;
		c.code_length = 6'(len);
		keep = (len >= 32) ? '1 : ((32'd1 << len) - 32'd1);
		// bits above the code must be ignored; half the loads carry junk there
		if ($urandom_range(1) == 1)
			c.code_bits = (c.code_bits & ~keep) | (bits & keep);
		else
			c.code_bits = bits & keep;
		send_cmd(c);
	endtask

	// Decode on an empty tree, unused opcode, refused code lengths
	task automatic test_empty_table();
		send_bit(1'b0);
		send_bit(1'b1);
		send_op(OP_UNUSED);
		send_load(8'h5A, 0, 32'h1);
		send_load(8'h5A, 33, 32'hFFFF_FFFF);
		send_load(8'h5A, 63, 32'h0);
		send_bit(1'b1);
	endtask

	// Small tree, extension through a leaf, symbol on an inner node, clear
	task automatic test_tree_edits();
		send_load(8'h00, 1, 32'b0);
		send_load(8'hFF, 2, 32'b10);
		send_load(8'hA5, 2, 32'b11);
		send_bit(1'b0);
		send_bit(1'b1); send_bit(1'b0);
		send_bit(1'b1); send_bit(1'b1);
		// leaf 0 gets children and stops being a leaf
		send_load(8'h3C, 3, 32'b000);
		send_bit(1'b0); send_bit(1'b0); send_bit(1'b0);
		send_bit(1'b0); send_bit(1'b1);
		// inner node 1 holds a symbol that never shows
		send_load(8'h77, 1, 32'b1);
		send_bit(1'b1); send_bit(1'b1);
		send_op(OP_CLEAR);
		send_bit(1'b0);
	endtask

	// Longest codes, and a clear in the middle of a walk
	task automatic test_long_codes();
		send_op(OP_CLEAR);
		send_load(8'h11, 32, 32'hFFFF_FFFF);
		send_load(8'hEE, 32, 32'h0000_0000);
		repeat (32) send_bit(1'b1);
		repeat (32) send_bit(1'b0);
		send_bit(1'b1); send_bit(1'b0);
		repeat (5) send_bit(1'b1);
		send_op(OP_CLEAR);
		send_bit(1'b0);
	endtask

	// Fill the table to the last node, with loads one node too big on the way
	task automatic test_table_full();
		logic [31:0] p;
		int unsigned d, rem, len, n;
		send_op(OP_CLEAR);
		while (nodes_used < TB_NODES) begin
			p   = $urandom();
			d   = tree_reach(32, p, n);
			rem = TB_NODES - nodes_used;
			if (d < 32) begin
				len = (d + rem > 32) ? 32 : d + rem;
				if (len < 32 && $urandom_range(1) == 1)
					send_load(8'($urandom()), len + 1, p >> (31 - len));
				send_load(8'($urandom()), len, p >> (32 - len));
			end
		end
		// full: a new path is refused, a path that exists is still relabeled
		do begin
			p = $urandom();
			d = tree_reach(32, p, n);
		end while (d >= 32);
		send_load(8'($urandom()), 32, p);
		if (d > 0)
			send_load(8'($urandom()), d, p >> (32 - d));
		repeat (40) send_bit(1'($urandom()));
		send_op(OP_CLEAR);
	endtask

	// One random prefix code: load it, then stream encoded symbols with some noise
	task automatic run_episode();
		logic [31:0] cb [$];
		int unsigned cl [$];
		logic [7:0]  sy [$];
		int unsigned ord [$];
		int unsigned k, maxlen, j, t, b, i;
		bit          chain;
		if ($urandom_range(99) < 80)
			send_op(OP_CLEAR);
		chain  = ($urandom_range(99) < 15);
		k      = chain ? $urandom_range(33, 2) : $urandom_range(24, 2);
		maxlen = chain ? 32 : (($urandom_range(99) < 70) ? 8 : 16);
		// grow the code by splitting leaves; a chain always splits the deepest
		cb.push_back('0);
		cl.push_back(0);
		while (cb.size() < k) begin
			j = chain ? cb.size() - 1 : $urandom_range(cb.size() - 1);
			if (cl[j] < maxlen) begin
				cb[j] = cb[j] << 1;
				cl[j] = cl[j] + 1;
				cb.push_back(cb[j] | 32'd1);
				cl.push_back(cl[j]);
			end
		end
		for (i = 0; i < k; i++) begin
			sy.push_back(8'($urandom()));
			ord.push_back(i);
		end
		for (i = k - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = ord[i];
			ord[i] = ord[j];
			ord[j] = t;
		end
		// a few codes left out so that some walks hit a missing child
		for (i = 0; i < k; i++)
			if ($urandom_range(99) >= 8)
				send_load(sy[ord[i]], cl[ord[i]], cb[ord[i]]);
		repeat ($urandom_range(16, 4)) begin
			if ($urandom_range(99) < 6) begin
				case ($urandom_range(4))
					0: send_op(OP_UNUSED);
					1: send_load(8'($urandom()),
						($urandom_range(1) == 1) ? 0 : $urandom_range(63, 33), $urandom());
					2: send_load(8'($urandom()), $urandom_range(32, 1), $urandom());
					3: send_op(OP_CLEAR);
					default: send_bit(1'($urandom()));
				endcase
			end
			j = $urandom_range(k - 1);
			for (b = cl[j]; b > 0; b--)
				send_bit(cb[j][b - 1] ^ ($urandom_range(99) < 4));
		end
	endtask

	task automatic test_random_streams(input int upto);
		while (items_sent < upto)
			run_episode();
	endtask

	// No idling on either side
	task automatic test_back_to_back(input int extra);
		int upto;
		upto       = items_sent + extra;
		burst_mode = 1'b1;
		while (items_sent < upto)
			run_episode();
		burst_mode = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		burst_mode   = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		tree_clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_tree_edits();
		test_long_codes();
		test_table_full();
		test_random_streams(1500);
		test_back_to_back(400);

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d transactions: %0d clears, %0d loads, %0d stream bits, %0d unused",
			items_sent, n_clear, n_load, n_bits, n_other);
		$display("Checked %0d results: %0d symbols, %0d full, %0d bad length, %0d missing child",
			n_checked, n_decoded, n_full, n_badlen, n_nochild);
		if (err_cnt == 0 && results_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
